// ===== sv/vfc_pkg.sv =====
package vfc_pkg;

  localparam int COORD_W   = 4;
  localparam int KIND_W    = 8;
  localparam int SIDE_W    = 3;
  localparam int NUM_SIDES = 6;

  localparam int DEF_WIDTH_X  = 16;
  localparam int DEF_HEIGHT_Y = 16;
  localparam int DEF_DEPTH_Z  = 16;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } vfc_action_t;

  // Scan sequence: one memory read per step, data is registered and lands in the next step.
  typedef enum logic [2:0] {
    STEP_CENTER,
    STEP_TOP,
    STEP_BOTTOM,
    STEP_RIGHT,
    STEP_LEFT,
    STEP_BACK,
    STEP_FRONT,
    STEP_DRAIN
  } vfc_step_t;

  typedef struct packed {
    logic      load;
    logic      scan;
    vfc_step_t step;
    logic      pop;
  } vfc_cmd_t;

  typedef struct packed {
    logic action;
    logic in_chunk;
    logic last;
  } vfc_sts_t;

endpackage

// ===== sv/vfc_in_if.sv =====
interface vfc_in_if;
  import vfc_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [COORD_W-1:0] pos_z;
  logic [KIND_W-1:0]  kind_in;

  modport source (output valid, action, pos_x, pos_y, pos_z, kind_in, input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z, kind_in, output ready);

endinterface

// ===== sv/vfc_out_if.sv =====
interface vfc_out_if;
  import vfc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [COORD_W-1:0] out_z;
  logic [SIDE_W-1:0]  side;
  logic [KIND_W-1:0]  kind_out;
  logic               has_face;
  logic               last;

  modport source (output valid, out_x, out_y, out_z, side, kind_out, has_face, last,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, side, kind_out, has_face, last,
                  output ready);

endinterface

// ===== sv/vfc_ctrl.sv =====
module vfc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  vfc_pkg::vfc_sts_t sts,
  output vfc_pkg::vfc_cmd_t cmd
);
  import vfc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t    state;
  vfc_step_t step;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);

  assign cmd.load = (state == ST_IDLE) && in_valid;
  assign cmd.scan = (state == ST_SCAN);
  assign cmd.step = step;
  assign cmd.pop  = (state == ST_EMIT) && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_CENTER;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step <= STEP_CENTER;
          if (in_valid && (sts.action == ACT_QUERY)) begin
            state <= sts.in_chunk ? ST_SCAN : ST_EMIT;
          end
        end
        ST_SCAN: begin
          step <= vfc_step_t'(step + 3'd1);
          if (step == STEP_DRAIN) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_ready && sts.last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/vfc_dp.sv =====
module vfc_dp #(
  parameter int WIDTH_X  = vfc_pkg::DEF_WIDTH_X,
  parameter int HEIGHT_Y = vfc_pkg::DEF_HEIGHT_Y,
  parameter int DEPTH_Z  = vfc_pkg::DEF_DEPTH_Z
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [vfc_pkg::KIND_W-1:0]  cfg_wdata,
  input  logic                        action,
  input  logic [vfc_pkg::COORD_W-1:0] pos_x,
  input  logic [vfc_pkg::COORD_W-1:0] pos_y,
  input  logic [vfc_pkg::COORD_W-1:0] pos_z,
  input  logic [vfc_pkg::KIND_W-1:0]  kind_in,
  input  vfc_pkg::vfc_cmd_t           cmd,
  output vfc_pkg::vfc_sts_t           sts,
  output logic [vfc_pkg::COORD_W-1:0] out_x,
  output logic [vfc_pkg::COORD_W-1:0] out_y,
  output logic [vfc_pkg::COORD_W-1:0] out_z,
  output logic [vfc_pkg::SIDE_W-1:0]  side,
  output logic [vfc_pkg::KIND_W-1:0]  kind_out,
  output logic                        has_face,
  output logic                        last
);
  import vfc_pkg::*;

  localparam int CELLS  = WIDTH_X * HEIGHT_Y * DEPTH_Z;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PLANE  = HEIGHT_Y * DEPTH_Z;

  logic [KIND_W-1:0] mem [CELLS];

  logic [KIND_W-1:0]    air_code;
  logic [COORD_W-1:0]   x_q, y_q, z_q;
  logic [KIND_W-1:0]    kind;
  logic                 is_air;
  logic [NUM_SIDES-1:0] mask;
  logic [KIND_W-1:0]    rd_data;

  logic [NUM_SIDES-1:0] bnd;
  logic [COORD_W:0]     xe, ye, ze;
  logic [ADDR_W-1:0]    rd_addr, wr_addr;
  logic                 in_inside;
  logic [2:0]           cap_side;
  logic                 cap_exposed;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W:0] cx,
                                                   input logic [COORD_W:0] cy,
                                                   input logic [COORD_W:0] cz);
    int idx;
    idx = int'(cx) * PLANE + int'(cy) * DEPTH_Z + int'(cz);
    return idx[ADDR_W-1:0];
  endfunction

  assign in_inside = (32'(pos_x) < WIDTH_X) && (32'(pos_y) < HEIGHT_Y) &&
                     (32'(pos_z) < DEPTH_Z);
  assign wr_addr   = cell_addr({1'b0, pos_x}, {1'b0, pos_y}, {1'b0, pos_z});

  assign xe = {1'b0, x_q};
  assign ye = {1'b0, y_q};
  assign ze = {1'b0, z_q};

  assign bnd[0] = (32'(y_q) == HEIGHT_Y - 1);
  assign bnd[1] = (y_q == '0);
  assign bnd[2] = (x_q == '0);
  assign bnd[3] = (32'(x_q) == WIDTH_X - 1);
  assign bnd[4] = (32'(z_q) == DEPTH_Z - 1);
  assign bnd[5] = (z_q == '0);

  always_comb begin
    unique case (cmd.step)
      STEP_TOP:    rd_addr = cell_addr(xe, ye + 1'b1, ze);
      STEP_BOTTOM: rd_addr = cell_addr(xe, ye - 1'b1, ze);
      STEP_RIGHT:  rd_addr = cell_addr(xe - 1'b1, ye, ze);
      STEP_LEFT:   rd_addr = cell_addr(xe + 1'b1, ye, ze);
      STEP_BACK:   rd_addr = cell_addr(xe, ye, ze + 1'b1);
      STEP_FRONT:  rd_addr = cell_addr(xe, ye, ze - 1'b1);
      default:     rd_addr = cell_addr(xe, ye, ze);
    endcase
  end

  // neighbor data read at one step is registered and arrives at the next step
  assign cap_side    = 3'(cmd.step) - 3'(STEP_BOTTOM);
  assign cap_exposed = !is_air && (bnd[cap_side] || (rd_data == air_code));

  always_ff @(posedge clk) begin
    if (cmd.load && (action == ACT_WRITE) && in_inside) begin
      mem[wr_addr] <= kind_in;
    end
    if (cmd.scan) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      air_code <= '0;
    end else if (cfg_we) begin
      air_code <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_q    <= pos_x;
      y_q    <= pos_y;
      z_q    <= pos_z;
      kind   <= '0;
      is_air <= 1'b1;
      mask   <= '0;
    end else if (cmd.scan) begin
      if (cmd.step == STEP_TOP) begin
        kind   <= rd_data;
        is_air <= (rd_data == air_code);
      end else if (cmd.step != STEP_CENTER) begin
        mask[cap_side] <= cap_exposed;
      end
    end else if (cmd.pop) begin
      mask <= mask & (mask - 1'b1);
    end
  end

  always_comb begin
    side = '0;
    for (int s = NUM_SIDES - 1; s >= 0; s--) begin
      if (mask[s]) begin
        side = SIDE_W'(s);
      end
    end
  end

  assign out_x    = x_q;
  assign out_y    = y_q;
  assign out_z    = z_q;
  assign kind_out = kind;
  assign has_face = (mask != '0);
  assign last     = ((mask & (mask - 1'b1)) == '0);

  assign sts.action   = action;
  assign sts.in_chunk = in_inside;
  assign sts.last     = last;

endmodule

// ===== sv/voxel_face_culling.sv =====
// Voxel face culling over one chunk of voxel kinds.
// item channel (sink): action 0 stores kind_in at pos_x/y/z, action 1 queries
// the exposed faces of that voxel. result channel (source): one response per
// exposed face in order top, bottom, right, left, back, front; a single
// response with has_face 0 for air, fully hidden or out-of-chunk voxels;
// last marks the final response of a query.
// cfg_we/cfg_wdata load air_code, the kind treated as empty.
// Timing: a write is stored when it is taken, and the block stays ready. A query
// inside the chunk scans the center and six neighbors through the single read
// port of the voxel memory, then a drain step, before its first response is
// valid; each further response follows once the one before is taken. A query
// outside the chunk answers in the cycle after it is taken. One request is in
// flight at a time: a query holds the block until its last response is taken.
// Reset clears the control and sets air_code to 0; the voxel memory is not
// cleared and must be written before it is queried.
// A stalled receiver holds the current response steady and the block takes
// no new request until the last response of the query is taken.
module voxel_face_culling #(
  parameter int WIDTH_X  = vfc_pkg::DEF_WIDTH_X,
  parameter int HEIGHT_Y = vfc_pkg::DEF_HEIGHT_Y,
  parameter int DEPTH_Z  = vfc_pkg::DEF_DEPTH_Z
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [vfc_pkg::KIND_W-1:0] cfg_wdata,
  vfc_in_if.sink                     item,
  vfc_out_if.source                  result
);
  import vfc_pkg::*;

  vfc_cmd_t cmd;
  vfc_sts_t sts;

  vfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vfc_dp #(
    .WIDTH_X  (WIDTH_X),
    .HEIGHT_Y (HEIGHT_Y),
    .DEPTH_Z  (DEPTH_Z)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .action    (item.action),
    .pos_x     (item.pos_x),
    .pos_y     (item.pos_y),
    .pos_z     (item.pos_z),
    .kind_in   (item.kind_in),
    .cmd       (cmd),
    .sts       (sts),
    .out_x     (result.out_x),
    .out_y     (result.out_y),
    .out_z     (result.out_z),
    .side      (result.side),
    .kind_out  (result.kind_out),
    .has_face  (result.has_face),
    .last      (result.last)
  );

endmodule

// ===== sv/vfc_checker.sv =====
module vfc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_action,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [vfc_pkg::SIDE_W-1:0]  out_side,
  input logic                        out_has_face,
  input logic                        out_last
);
  import vfc_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("request taken while a response is pending");

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_action == ACT_QUERY)) |=> !in_ready)
    else $error("new request taken right after a query");

  a_no_face_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_has_face) |-> (out_last && (out_side == '0)))
    else $error("response without face is not the final one");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("response after the final one of a query");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_side) && $stable(out_last)))
    else $error("stalled response changed");

endmodule

bind voxel_face_culling vfc_checker u_vfc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item.valid),
  .in_ready     (item.ready),
  .in_action    (item.action),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_side     (result.side),
  .out_has_face (result.has_face),
  .out_last     (result.last)
);
